### rtl/cpml_pkg.sv
package cpml_pkg;

  localparam int NUM_POINTS_DEF = 4096;
  localparam int MAX_GRADE_DEF  = 15;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  localparam logic KIND_E = 1'b0;
  localparam logic KIND_H = 1'b1;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic REG_E_SCALE = 1'b0;
  localparam logic REG_H_SCALE = 1'b1;

  localparam int COEF_W = 17;

  typedef struct packed {
    logic               func;
    logic               field_kind;
    logic [1:0]         axis;
    logic [3:0]         grade;
    logic [11:0]        point;
    logic               slot;
    logic signed [31:0] diff;
    logic signed [31:0] field_in;
    logic [COEF_W-1:0]  coef_b;
    logic [COEF_W-1:0]  coef_c;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] field_out;
    logic signed [31:0] aux_out;
  } out_beat_t;

  typedef struct packed {
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] c;
  } coef_pair_t;

  typedef struct packed {
    logic               field_kind;
    logic               slot;
    logic signed [31:0] diff;
    logic signed [31:0] field_in;
  } upd_req_t;

  typedef struct packed {
    logic               field_kind;
    logic               slot;
    logic signed [31:0] aux;
    logic signed [31:0] field_in;
  } aux_res_t;

  // Q.16 round half up, then clamp to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + 66'sd32768) >>> 16;
    if (r > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (r < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

endpackage

### rtl/cpml_boundary_field_update.sv
// CPML auxiliary-field update. An update beat reads the auxiliary value for its point, field
// kind and slot, forms aux = b*aux + c*diff from the coefficient tables, writes it back and
// returns the field corrected by the scaled auxiliary value; a load beat writes one b/c table
// entry and returns nothing. One beat is taken per clock unless clearing, a hazard or
// back-pressure stalls the input. An update that hits the same auxiliary entry as one of the
// two updates before it waits until that entry has been written back, since the auxiliary
// store has a single write port fed from the second stage. After reset the store is cleared
// one entry per cycle, all 4*NUM_POINTS entries (16384 by default), with in_ready low;
// register writes are taken throughout.
module cpml_boundary_field_update
  import cpml_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF,
  parameter int MAX_GRADE  = MAX_GRADE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(NUM_POINTS * 4);
  localparam int TW = $clog2(6 * (MAX_GRADE + 1));
  localparam int GW = $clog2(MAX_GRADE + 1);

  logic signed [31:0] e_scale;
  logic signed [31:0] h_scale;

  logic          is_update;
  logic          axis_ok, point_ok, grade_ok;
  logic [3:0]    grade_upd;
  logic [GW-1:0] g_sel;
  logic [2:0]    row;
  logic [TW-1:0] tix;
  logic          accept, upd_take, load_we;
  logic [AW-1:0] in_addr;
  upd_req_t      in_req;
  coef_pair_t    load_coef;
  coef_pair_t    coef;

  logic     res_valid, res_ready;
  aux_res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_scale <= '0;
      h_scale <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_E_SCALE: e_scale <= $signed(cfg_data);
        REG_H_SCALE: h_scale <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign is_update = (in_data.func == FUNC_UPDATE);
  assign axis_ok   = (in_data.axis != AXIS_NONE);
  assign point_ok  = (32'(in_data.point) < 32'(NUM_POINTS));
  assign grade_ok  = (32'(in_data.grade) <= 32'(MAX_GRADE));

  // magnetic updates use the entry one grade down, floored at zero
  assign grade_upd = (in_data.field_kind == KIND_H && in_data.grade != 4'd0)
                   ? in_data.grade - 4'd1 : in_data.grade;

  always_comb begin
    if (is_update) begin
      g_sel = (32'(grade_upd) > 32'(MAX_GRADE)) ? GW'(MAX_GRADE) : GW'(grade_upd);
    end else begin
      g_sel = GW'(in_data.grade);
    end
  end

  assign row = ((in_data.field_kind == KIND_H) ? 3'd3 : 3'd0) + {1'b0, in_data.axis};
  assign tix = TW'(int'(row) * (MAX_GRADE + 1) + int'(g_sel));

  assign accept   = in_valid && in_ready;
  assign upd_take = accept && is_update && axis_ok && point_ok;
  assign load_we  = accept && !is_update && axis_ok && grade_ok;

  assign in_addr = AW'({in_data.point, in_data.field_kind, in_data.slot});

  assign in_req.field_kind = in_data.field_kind;
  assign in_req.slot       = in_data.slot;
  assign in_req.diff       = in_data.diff;
  assign in_req.field_in   = in_data.field_in;

  assign load_coef.b = in_data.coef_b;
  assign load_coef.c = in_data.coef_c;

  cpml_coef_table #(
    .MAX_GRADE (MAX_GRADE)
  ) u_coef (
    .clk   (clk),
    .we    (load_we),
    .waddr (tix),
    .wdata (load_coef),
    .re    (upd_take),
    .raddr (tix),
    .rdata (coef)
  );

  cpml_aux_path #(
    .NUM_POINTS (NUM_POINTS)
  ) u_aux (
    .clk       (clk),
    .rst       (rst),
    .ready     (in_ready),
    .take      (upd_take),
    .in_addr   (in_addr),
    .in_req    (in_req),
    .coef      (coef),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  cpml_field_path u_field (
    .clk       (clk),
    .rst       (rst),
    .e_scale   (e_scale),
    .h_scale   (h_scale),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/cpml_coef_table.sv
module cpml_coef_table
  import cpml_pkg::*;
#(
  parameter int MAX_GRADE = MAX_GRADE_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(6*(MAX_GRADE+1))-1:0]     waddr,
  input  coef_pair_t                             wdata,
  input  logic                                   re,
  input  logic [$clog2(6*(MAX_GRADE+1))-1:0]     raddr,
  output coef_pair_t                             rdata
);

  localparam int DEPTH = 6 * (MAX_GRADE + 1);

  coef_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cpml_aux_path.sv
module cpml_aux_path
  import cpml_pkg::*;
#(
  parameter int NUM_POINTS = NUM_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  output logic                              ready,
  input  logic                              take,
  input  logic [$clog2(NUM_POINTS*4)-1:0]   in_addr,
  input  upd_req_t                          in_req,
  input  coef_pair_t                        coef,
  output logic                              res_valid,
  input  logic                              res_ready,
  output aux_res_t                          res
);

  localparam int DEPTH = NUM_POINTS * 4;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [31:0] mem [DEPTH];

  logic          clearing;
  logic [AW-1:0] clr_addr;

  logic               v1;
  logic [AW-1:0]      addr1;
  upd_req_t           req1;
  logic signed [31:0] aux_old;

  logic               v2;
  logic [AW-1:0]      addr2;
  upd_req_t           req2;
  logic signed [49:0] pb;
  logic signed [49:0] pc;

  logic adv1, adv2, adv3;
  logic hazard;
  logic wb;
  logic signed [31:0] aux_new;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign adv3 = !res_valid || res_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  // hold a beat whose entry is still on its way back to the store
  assign hazard = (v1 && addr1 == in_addr) || (v2 && addr2 == in_addr);
  assign ready  = !clearing && adv1 && !hazard;

  assign aux_new = round_sat(66'(pb) + 66'(pc));
  assign wb      = v2 && adv2;

  assign mem_we    = clearing || wb;
  assign mem_waddr = clearing ? clr_addr : addr2;
  assign mem_wdata = clearing ? 32'd0 : aux_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (take) begin
      aux_old <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST) begin
          clearing <= 1'b0;
        end
      end
      if (adv1) begin
        v1 <= take;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        res_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr1 <= in_addr;
      req1  <= in_req;
    end
    if (adv2 && v1) begin
      addr2 <= addr1;
      req2  <= req1;
      pb    <= $signed({1'b0, coef.b}) * aux_old;
      pc    <= $signed({1'b0, coef.c}) * req1.diff;
    end
    if (adv3 && v2) begin
      res.field_kind <= req2.field_kind;
      res.slot       <= req2.slot;
      res.aux        <= aux_new;
      res.field_in   <= req2.field_in;
    end
  end

  a_no_take_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !take)
    else $error("beat taken during store clear");

  a_take_fills_s1: assert property (@(posedge clk) disable iff (rst)
    take |=> v1)
    else $error("taken beat lost before first stage");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (v2 && adv2) |-> !(take && in_addr == addr2))
    else $error("read of entry under write-back");

endmodule

### rtl/cpml_field_path.sv
module cpml_field_path
  import cpml_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] e_scale,
  input  logic signed [31:0] h_scale,
  input  logic               res_valid,
  output logic               res_ready,
  input  aux_res_t           res,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data
);

  logic               v4;
  logic signed [31:0] aux4;
  logic signed [31:0] fin4;
  logic               sub4;
  logic signed [63:0] prod4;

  logic               adv4, adv5;
  logic signed [31:0] scale;
  logic signed [65:0] fshift;
  logic signed [65:0] total;

  assign adv5      = !out_valid || out_ready;
  assign adv4      = !v4 || adv5;
  assign res_ready = adv4;

  assign scale  = (res.field_kind == KIND_H) ? h_scale : e_scale;
  assign fshift = 66'(fin4) <<< 16;
  assign total  = sub4 ? (fshift - 66'(prod4)) : (fshift + 66'(prod4));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv4) begin
        v4 <= res_valid;
      end
      if (adv5) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && res_valid) begin
      aux4  <= res.aux;
      fin4  <= res.field_in;
      sub4  <= (res.field_kind == KIND_H) ? res.slot : !res.slot;
      prod4 <= res.aux * scale;
    end
    if (adv5 && v4) begin
      out_data.field_out <= round_sat(total);
      out_data.aux_out   <= aux4;
    end
  end

  a_out_from_s4: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("result beat without a product stage beat");

endmodule

### bench/cpml_update_monitor.sv
`timescale 1ns / 1ps
module cpml_update_monitor
  import cpml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);

  localparam int GRADES    = MAX_GRADE_DEF + 1;
  localparam int AUX_WORDS = 4 * NUM_POINTS_DEF;

  logic [COEF_W-1:0]  decay_tab    [0:1][0:2][0:GRADES-1];
  logic [COEF_W-1:0]  coupling_tab [0:1][0:2][0:GRADES-1];
  logic signed [31:0] aux_mem      [0:AUX_WORDS-1];
  logic signed [31:0] e_scale_r;
  logic signed [31:0] h_scale_r;
  out_beat_t          corrected_q  [$];

  // add one half, floor to Q16.16, clamp to the 32-bit range
  function automatic logic signed [31:0] q16_round_clamp(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > longint'(32'sh7fffffff)) r = longint'(32'sh7fffffff);
    else if (r < longint'(32'sh80000000)) r = longint'(32'sh80000000);
    return r[31:0];
  endfunction

  task automatic predict_correction(input in_beat_t t);
    logic [3:0]         g;
    int unsigned        aix;
    longint             acc;
    longint             prod;
    longint             total;
    logic signed [31:0] aux_new;
    logic signed [31:0] scale;
    out_beat_t          want;
    if (t.axis == AXIS_NONE) return;
    if (t.func == FUNC_LOAD) begin
      decay_tab[t.field_kind][t.axis][t.grade]    = t.coef_b;
      coupling_tab[t.field_kind][t.axis][t.grade] = t.coef_c;
      return;
    end
    g = (t.field_kind == KIND_H && t.grade != 4'd0) ? t.grade - 4'd1 : t.grade;
    aix = 32'({t.point, t.field_kind, t.slot});
    acc = longint'(decay_tab[t.field_kind][t.axis][g]) * longint'(aux_mem[aix])
        + longint'(coupling_tab[t.field_kind][t.axis][g]) * longint'($signed(t.diff));
    aux_new = q16_round_clamp(acc);
    aux_mem[aix] = aux_new;
    scale = (t.field_kind == KIND_E) ? e_scale_r : h_scale_r;
    prod  = longint'(aux_new) * longint'(scale);
    total = longint'($signed(t.field_in)) * 64'sd65536;
    // electric slot 0 and magnetic slot 1 subtract
    if ((t.field_kind == KIND_E) == (t.slot == 1'b0)) total = total - prod;
    else total = total + prod;
    want.field_out = q16_round_clamp(total);
    want.aux_out   = aux_new;
    corrected_q.push_back(want);
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    results_seen++;
    if (corrected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: field_out %h aux_out %h", got.field_out, got.aux_out);
      return;
    end
    want = corrected_q.pop_front();
    if (got.field_out !== want.field_out || got.aux_out !== want.aux_out) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: field_out exp %h got %h, aux_out exp %h got %h",
                 results_seen, want.field_out, got.field_out, want.aux_out, got.aux_out);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (aux_mem[i]) aux_mem[i] = '0;
      e_scale_r = '0;
      h_scale_r = '0;
      corrected_q.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_E_SCALE) e_scale_r = cfg_data;
        else h_scale_r = cfg_data;
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) predict_correction(in_data);
    end
    pending <= corrected_q.size();
  end

endmodule

### bench/tb_cpml_boundary_field_update.sv
`timescale 1ns / 1ps
module tb_cpml_boundary_field_update;
  import cpml_pkg::*;

  localparam int BLOCK_BEATS = 229;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_E_SCALE;
  logic [31:0] cfg_data  = '0;

  int mismatches;
  int pending;
  int results_seen;
  int send_idle_pct = 16;
  int recv_idle_pct = 82;
  int loads_sent;
  int updates_sent;
  int ignored_sent;
  int fails;
  bit loaded [0:1][0:2][0:15];

  cpml_boundary_field_update u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cpml_update_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_cpml_boundary_field_update: errors");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic in_beat_t mk_beat(input logic func, input logic kind,
                                       input logic [1:0] axis, input logic [3:0] grade,
                                       input logic [11:0] point, input logic slot,
                                       input logic [31:0] diff, input logic [31:0] fin,
                                       input logic [16:0] b, input logic [16:0] c);
    in_beat_t t;
    t.func = func;
    t.field_kind = kind;
    t.axis = axis;
    t.grade = grade;
    t.point = point;
    t.slot = slot;
    t.diff = diff;
    t.field_in = fin;
    t.coef_b = b;
    t.coef_c = c;
    return t;
  endfunction

  function automatic logic [16:0] pick_coef();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 17'($urandom_range(65536));
    if (sel < 85) return 17'($urandom_range(131071));
    case ($urandom_range(2))
      0: return 17'd0;
      1: return 17'd65536;
      default: return 17'h1ffff;
    endcase
  endfunction

  function automatic logic [31:0] pick_q16();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 32'($urandom_range(2097152)) - 32'd1048576;
    if (sel < 60) begin
      case ($urandom_range(4))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h0;
        3: return 32'h1;
        default: return 32'hffffffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [11:0] pick_point();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return 12'($urandom_range(7));
    if (sel < 60) return $urandom_range(1) ? 12'd4095 : 12'd0;
    return 12'($urandom_range(4095));
  endfunction

  function automatic in_beat_t rand_beat();
    logic [127:0] raw;
    in_beat_t     t;
    logic [3:0]   g;
    int           sel;
    raw = {$urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(in_beat_t)-1:0];
    sel = $urandom_range(99);
    if (sel < 5) begin
      t.axis = AXIS_NONE;
      return t;
    end
    t.axis = 2'($urandom_range(2));
    t.coef_b = pick_coef();
    t.coef_c = pick_coef();
    if (sel < 35) begin
      t.func = FUNC_LOAD;
      return t;
    end
    t.func = FUNC_UPDATE;
    g = (t.field_kind == KIND_H && t.grade != 4'd0) ? t.grade - 4'd1 : t.grade;
    // fill the entry first if nothing has been loaded there yet
    if (!loaded[t.field_kind][t.axis][g]) begin
      t.func = FUNC_LOAD;
      t.grade = g;
      return t;
    end
    t.point = pick_point();
    t.diff = pick_q16();
    t.field_in = pick_q16();
    return t;
  endfunction

  task automatic push_beat(input in_beat_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    // hold the beat until taken
    do @(posedge clk); while (!in_ready);
    if (t.axis == AXIS_NONE) ignored_sent++;
    else if (t.func == FUNC_LOAD) begin
      loaded[t.field_kind][t.axis][t.grade] = 1'b1;
      loads_sent++;
    end else updates_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_scales(input logic [31:0] e_val, input logic [31:0] h_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_E_SCALE;
    cfg_data  <= e_val;
    @(posedge clk);
    cfg_index <= REG_H_SCALE;
    cfg_data  <= h_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int counted;
    in_beat_t t;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_scales(32'h00010000, 32'hffff0000);

    push_beat(mk_beat(FUNC_LOAD, KIND_E, 2'd0, 4'd0, 12'd0, 1'b0,
                      32'd0, 32'd0, 17'h10000, 17'h10000));
    push_beat(mk_beat(FUNC_LOAD, KIND_H, 2'd0, 4'd0, 12'd0, 1'b0,
                      32'd0, 32'd0, 17'h1ffff, 17'h1ffff));
    push_beat(mk_beat(FUNC_LOAD, KIND_E, 2'd2, 4'd15, 12'd0, 1'b0,
                      32'd0, 32'd0, 17'h0, 17'h1ffff));
    push_beat(mk_beat(FUNC_LOAD, KIND_H, 2'd2, 4'd14, 12'd0, 1'b0,
                      32'd0, 32'd0, 17'h08000, 17'h04000));
    push_beat(mk_beat(FUNC_LOAD, KIND_E, 2'd1, 4'd7, 12'd0, 1'b0,
                      32'd0, 32'd0, 17'h0ffff, 17'h00001));
    push_beat(mk_beat(FUNC_LOAD, KIND_E, AXIS_NONE, 4'd0, 12'd0, 1'b0,
                      32'd0, 32'd0, 17'h0, 17'h0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, 2'd0, 4'd0, 12'd0, 1'b0,
                      32'h7fffffff, 32'h7fffffff, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, 2'd0, 4'd0, 12'd0, 1'b0,
                      32'h7fffffff, 32'h0, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, 2'd0, 4'd0, 12'd0, 1'b1,
                      32'h80000000, 32'h80000000, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_H, 2'd0, 4'd0, 12'd4095, 1'b0,
                      32'h80000000, 32'h00018000, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_H, 2'd0, 4'd1, 12'd4095, 1'b1,
                      32'h7fffffff, 32'hffff8000, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_H, 2'd0, 4'd1, 12'd4095, 1'b1,
                      32'h1, 32'h0, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, 2'd2, 4'd15, 12'd4095, 1'b1,
                      32'h80000000, 32'h7fffffff, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_H, 2'd2, 4'd15, 12'd0, 1'b0,
                      32'h00010000, 32'h80000000, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, 2'd1, 4'd7, 12'd2048, 1'b0,
                      32'h00008000, 32'hffffffff, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, 2'd1, 4'd7, 12'd2048, 1'b0,
                      32'hffff8000, 32'h00000001, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_E, AXIS_NONE, 4'd0, 12'd0, 1'b0,
                      32'h1, 32'h1, 17'd0, 17'd0));
    push_beat(mk_beat(FUNC_UPDATE, KIND_H, 2'd0, 4'd0, 12'd0, 1'b1,
                      32'h00020000, 32'h00010000, 17'd0, 17'd0));
    drain_results();

    for (int blk = 0; blk < 6; blk++) begin
      case (blk / 2)
        0: begin send_idle_pct = 16; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (blk)
        0: write_scales(32'h7fffffff, 32'h80000000);
        1: write_scales(32'h80000000, 32'h7fffffff);
        2: write_scales(32'h0, $urandom);
        3: write_scales($urandom, $urandom);
        4: write_scales(32'h00010000, 32'h00008000);
        default: write_scales($urandom, 32'h0);
      endcase
      counted = 0;
      while (counted < BLOCK_BEATS) begin
        t = rand_beat();
        push_beat(t);
        if (t.axis != AXIS_NONE) counted++;
      end
      drain_results();
    end

    fails = mismatches + pending;
    $display("covered %0d updates, %0d table loads and %0d ignored beats",
             updates_sent, loads_sent, ignored_sent);
    $display("seven scale settings, three idling patterns; %0d results compared, %0d missing",
             results_seen, pending);
    if (fails == 0) begin
      $display("tb_cpml_boundary_field_update: clean");
    end else begin
      $display("tb_cpml_boundary_field_update: errors");
    end
    $finish;
  end

endmodule

### cpml_boundary_field_update.f
rtl/cpml_pkg.sv
rtl/cpml_coef_table.sv
rtl/cpml_aux_path.sv
rtl/cpml_field_path.sv
rtl/cpml_boundary_field_update.sv
bench/cpml_update_monitor.sv
bench/tb_cpml_boundary_field_update.sv
